### design/wsrd_pkg.sv
// Shared widths and constants for the middle-square Weyl random draw block.
// No dependencies; imported by the channel interfaces and every module.
`default_nettype none
package wsrd_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;
  localparam int DIV_STEPS = WORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] WEYL_STEP = 64'hb5ad4eceda1ce2a9;
  localparam logic [WORD_W-1:0] MIX_ADD   = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;

  localparam int MIX_SHIFT_A = 30;
  localparam int MIX_SHIFT_B = 27;
  localparam int MIX_SHIFT_C = 31;
  localparam int HALF_SWAP   = HALF_W;

endpackage
`default_nettype wire

### design/wsrd_channels.sv
// Valid/ready channel interfaces for the seed, bound and draw words.
// Depends on wsrd_pkg for the word width.
`default_nettype none
interface wsrd_seed_if import wsrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] seed;
  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

interface wsrd_bound_if import wsrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] bound;
  modport source (output valid, output bound, input ready);
  modport sink   (input valid, input bound, output ready);
endinterface

interface wsrd_draw_if import wsrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] draw_value;
  logic              div_by_zero;
  modport source (output valid, output draw_value, output div_by_zero, input ready);
  modport sink   (input valid, input draw_value, input div_by_zero, output ready);
endinterface
`default_nettype wire

### design/wsrd_mul64.sv
// Iterative 64x64 multiplier, product modulo 2^64, on one 32x32 unit.
// Depends on wsrd_pkg.
`default_nettype none
module wsrd_mul64 import wsrd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic                   done,
  output logic [WORD_W-1:0]      p
);

  logic              busy_r;
  logic [1:0]        step_r;
  logic              done_r;
  logic [WORD_W-1:0] a_r, b_r;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] acc_r;
  logic [HALF_W-1:0] op_x, op_y;
  logic [WORD_W-1:0] mul_out;

  // low*low, then the two cross terms; high*high falls outside 2^64
  always_comb begin
    unique case (step_r)
      2'd0: begin
        op_x = a_r[HALF_W-1:0];
        op_y = b_r[HALF_W-1:0];
      end
      2'd1: begin
        op_x = a_r[HALF_W-1:0];
        op_y = b_r[WORD_W-1:HALF_W];
      end
      default: begin
        op_x = a_r[WORD_W-1:HALF_W];
        op_y = b_r[HALF_W-1:0];
      end
    endcase
    mul_out = {{HALF_W{1'b0}}, op_x} * {{HALF_W{1'b0}}, op_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r) begin
      prod_r <= mul_out;
      unique case (step_r)
        2'd0:    acc_r <= acc_r;
        2'd1:    acc_r <= prod_r;
        default: acc_r <= acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
      endcase
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

### design/wsrd_mod64.sv
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit a cycle.
// Depends on wsrd_pkg.
`default_nettype none
module wsrd_mod64 import wsrd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic [WORD_W-1:0]      remainder
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    dvd_r, den_r, rem_r;
  logic [WORD_W:0]      shifted, diff;
  logic [WORD_W-1:0]    rem_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[WORD_W-1]};
    diff    = shifted - {1'b0, den_r};
    rem_nxt = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

### design/weyl_square_random_draw.sv
// Bounded random draw from a 64-bit middle-square Weyl generator.
// Depends on wsrd_pkg, wsrd_channels, wsrd_mul64 and wsrd_mod64.
//
// Channels: cfg_ch writes the 64-bit seed word (always ready). in_ch takes
// one bound word per request; out_ch returns draw_value and div_by_zero.
// The first request after reset seeds the generator from the seed register
// with two splitmix rounds; seed writes after that have no effect.
// Each request then squares the state, adds the stepped Weyl sum, swaps
// halves and reduces the word modulo bound in a bit-serial unit.
// The first draw takes four extra multiplies for the seeding; a zero bound
// skips the remainder pass. One request is worked at a time: the 64-step
// remainder loop and the 64-bit multiply on a single 32x32 unit bound the
// rate, and in_ch.ready is high only between requests.
// The result sits in an output register, so the next bound is taken while
// the receiver stalls; a new result waits until that register drains.
// Reset (synchronous, rst_n low) clears the generator, the seed and out_ch.valid.
`default_nettype none
module weyl_square_random_draw import wsrd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wsrd_seed_if.sink   cfg_ch,
  wsrd_bound_if.sink  in_ch,
  wsrd_draw_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX1_W,
    ST_MIX2,
    ST_MIX2_W,
    ST_SQ,
    ST_SQ_W,
    ST_DIV_W,
    ST_OUT
  } state_t;

  state_t            state_r;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] rstate_r;
  logic [WORD_W-1:0] weyl_r;
  logic              seeded_r;
  logic              mix_sel_r;
  logic [WORD_W-1:0] v_r;
  logic [WORD_W-1:0] bound_r;
  logic [WORD_W-1:0] res_r;
  logic              res_dbz_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_value_r;
  logic              out_dbz_r;

  logic              mul_start, mul_done;
  logic [WORD_W-1:0] mul_a, mul_b, mul_p;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_rem;
  logic [WORD_W-1:0] mix_fin, sq_sum, gen_word;
  logic              in_acc;
  logic              out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = rstate_r;
    mul_b     = rstate_r;
    unique case (state_r)
      ST_MIX1: begin
        mul_start = 1'b1;
        mul_a     = v_r ^ (v_r >> MIX_SHIFT_A);
        mul_b     = MIX_MUL_A;
      end
      ST_MIX2: begin
        mul_start = 1'b1;
        mul_a     = v_r ^ (v_r >> MIX_SHIFT_B);
        mul_b     = MIX_MUL_B;
      end
      ST_SQ: begin
        mul_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
    mix_fin   = mul_p ^ (mul_p >> MIX_SHIFT_C);
    sq_sum    = mul_p + weyl_r;
    gen_word  = {sq_sum[HALF_SWAP-1:0], sq_sum[WORD_W-1:HALF_SWAP]};
    div_start = (state_r == ST_SQ_W) && mul_done && (bound_r != '0);
  end

  wsrd_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  wsrd_mod64 u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (gen_word),
    .divisor   (bound_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= '0;
      rstate_r    <= '0;
      weyl_r      <= '0;
      seeded_r    <= 1'b0;
      mix_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        seed_r <= cfg_ch.seed;
      end
      // drop the held word once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            bound_r <= in_ch.bound;
            if (!seeded_r) begin
              v_r       <= seed_r + MIX_ADD;
              mix_sel_r <= 1'b0;
              state_r   <= ST_MIX1;
            end else begin
              state_r <= ST_SQ;
            end
          end
        end
        ST_MIX1: state_r <= ST_MIX1_W;
        ST_MIX1_W: begin
          if (mul_done) begin
            v_r     <= mul_p;
            state_r <= ST_MIX2;
          end
        end
        ST_MIX2: state_r <= ST_MIX2_W;
        ST_MIX2_W: begin
          if (mul_done) begin
            if (!mix_sel_r) begin
              rstate_r  <= mix_fin;
              v_r       <= mix_fin + MIX_ADD;
              mix_sel_r <= 1'b1;
              state_r   <= ST_MIX1;
            end else begin
              weyl_r   <= mix_fin;
              seeded_r <= 1'b1;
              state_r  <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          weyl_r  <= weyl_r + WEYL_STEP;
          state_r <= ST_SQ_W;
        end
        ST_SQ_W: begin
          if (mul_done) begin
            rstate_r <= gen_word;
            if (bound_r == '0) begin
              res_r     <= '0;
              res_dbz_r <= 1'b1;
              state_r   <= ST_OUT;
            end else begin
              state_r <= ST_DIV_W;
            end
          end
        end
        ST_DIV_W: begin
          if (div_done) begin
            res_r     <= div_rem;
            res_dbz_r <= 1'b0;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_value_r <= res_r;
            out_dbz_r   <= res_dbz_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ch.ready      = 1'b1;
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.draw_value = out_value_r;
  assign out_ch.div_by_zero = out_dbz_r;

endmodule
`default_nettype wire
